>>> design/assert_macros.svh
// Assertion macros shared by the list controller and datapath.
// Each macro expands to one labeled concurrent assertion that is disabled during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property prop must hold at every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Condition cond must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  `ASSERT_PROP(lbl, clk, rstn, !(cond), msg)

`endif

>>> design/sal_pkg.sv
// Package for the shift array list: request and status codes, job classes,
// controller states and the command and status structs. It depends on nothing.
package sal_pkg;

  localparam int unsigned REQ_W  = 3;
  localparam int unsigned POS_W  = 9;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned CNT_W  = 9;
  localparam int unsigned STAT_W = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_APPEND = 3'd0,
    REQ_POP    = 3'd1,
    REQ_INSERT = 3'd2,
    REQ_ERASE  = 3'd3,
    REQ_READ   = 3'd4,
    REQ_WRITE  = 3'd5
  } req_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_EMPTY  = 2'd2,
    STAT_BADPOS = 2'd3
  } status_e;

  // What remains to be done for a request once it has been accepted.
  typedef enum logic [1:0] {
    JOB_DONE   = 2'd0,
    JOB_READ   = 2'd1,
    JOB_INSERT = 2'd2,
    JOB_ERASE  = 2'd3
  } job_e;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_SHIFT  = 2'd1,
    S_FINISH = 2'd2,
    S_RESP   = 2'd3
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic shift;
    logic finish;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    job_e acc_job;
    job_e cur_job;
    logic shift_more;
    logic out_free;
  } stat_t;

endpackage

>>> design/sal_ram.sv
// Generic simple dual-port RAM: one write port and one read port with registered read data.
// Stand-alone; used by the shift array list datapath for the element store.
module sal_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/sal_ctrl.sv
// Controller of the shift array list: sequences accept, shift, final write and response.
// Depends on sal_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sal_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  sal_pkg::stat_t stat_i,
  output sal_pkg::cmd_t  cmd_o
);

  import sal_pkg::*;

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          if (stat_i.acc_job == JOB_INSERT || stat_i.acc_job == JOB_ERASE) begin
            state_d = S_SHIFT;
          end else begin
            state_d = S_RESP;
          end
        end
      end
      S_SHIFT: begin
        cmd_o.shift = 1'b1;
        // The last pending move is written in the cycle that sees no more reads.
        if (!stat_i.shift_more) begin
          state_d = (stat_i.cur_job == JOB_INSERT) ? S_FINISH : S_RESP;
        end
      end
      S_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d      = S_RESP;
      end
      S_RESP: begin
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // An accepted insert or erase always goes on to the shift phase.
  `ASSERT_PROP(a_shift_follows_accept, clk_i, rst_ni,
               (cmd_o.capture && (stat_i.acc_job == JOB_INSERT ||
                stat_i.acc_job == JOB_ERASE)) |=> (state_q == S_SHIFT),
               "insert or erase did not enter the shift phase")

endmodule

>>> design/sal_dp.sv
// Datapath of the shift array list: element count, request decode, shift cursor,
// element store and the result register. Depends on sal_pkg, sal_ram and assert_macros.svh.
`include "assert_macros.svh"

module sal_dp #(
  parameter int unsigned DEPTH = 256
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  sal_pkg::cmd_t                      cmd_i,
  output sal_pkg::stat_t                     stat_o,
  input  logic [sal_pkg::REQ_W-1:0]          in_req_type_i,
  input  logic [sal_pkg::POS_W-1:0]          in_position_i,
  input  logic signed [sal_pkg::DATA_W-1:0]  in_value_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [sal_pkg::DATA_W-1:0]  out_read_data_o,
  output logic [sal_pkg::CNT_W-1:0]          out_element_count_o,
  output logic [sal_pkg::STAT_W-1:0]         out_status_o,
  output logic [sal_pkg::POS_W-1:0]          out_result_position_o
);

  import sal_pkg::*;

  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned CMPW = (CW > POS_W) ? CW : POS_W;

  logic [CW-1:0]     count_q, count_d;
  logic [CW-1:0]     cursor_q, cursor_d;
  logic [CW-1:0]     end_q, end_d;
  logic [CW-1:0]     pos_q, pos_d;
  logic [DATA_W-1:0] val_q, val_d;
  job_e              job_q, job_d;
  status_e           status_q, status_d;
  logic [POS_W-1:0]  rpos_q, rpos_d;
  logic              wr_pend_q, wr_pend_d;
  logic [AW-1:0]     wr_addr_q, wr_addr_d;

  logic              out_valid_q;
  logic [DATA_W-1:0] out_data_q;
  logic [CNT_W-1:0]  out_count_q;
  logic [STAT_W-1:0] out_status_q;
  logic [POS_W-1:0]  out_rpos_q;

  logic [CMPW-1:0]   cnt_ext, pos_ext;
  logic [CW-1:0]     pos_cw, cursor_dec, cursor_inc;
  logic              full, empty, pos_gt_cnt, pos_ge_cnt;
  job_e              acc_job;
  status_e           acc_status;
  logic [CW-1:0]     acc_count;
  logic [POS_W-1:0]  acc_rpos;
  logic              acc_we, acc_re;
  logic [AW-1:0]     acc_waddr;
  logic              shift_active;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_wdata, ram_rdata;

  assign cnt_ext    = CMPW'(count_q);
  assign pos_ext    = CMPW'(in_position_i);
  assign pos_cw     = pos_ext[CW-1:0];
  assign full       = (count_q == CW'(DEPTH));
  assign empty      = (count_q == '0);
  assign pos_gt_cnt = (pos_ext > cnt_ext);
  assign pos_ge_cnt = (pos_ext >= cnt_ext);

  // Decode the request against the current count.
  always_comb begin
    acc_job    = JOB_DONE;
    acc_status = STAT_OK;
    acc_count  = count_q;
    acc_rpos   = '0;
    acc_we     = 1'b0;
    acc_re     = 1'b0;
    acc_waddr  = count_q[AW-1:0];
    unique case (req_e'(in_req_type_i))
      REQ_APPEND: begin
        if (full) begin
          acc_status = STAT_FULL;
        end else begin
          acc_we    = 1'b1;
          acc_count = count_q + 1'b1;
        end
      end
      REQ_POP: begin
        if (empty) begin
          acc_status = STAT_EMPTY;
        end else begin
          acc_count = count_q - 1'b1;
        end
      end
      REQ_INSERT: begin
        if (pos_gt_cnt) begin
          acc_status = STAT_BADPOS;
        end else if (full) begin
          acc_status = STAT_FULL;
        end else begin
          acc_job   = JOB_INSERT;
          acc_count = count_q + 1'b1;
          acc_rpos  = in_position_i + 1'b1;
        end
      end
      REQ_ERASE: begin
        if (pos_ge_cnt) begin
          acc_status = STAT_BADPOS;
        end else begin
          acc_job   = JOB_ERASE;
          acc_count = count_q - 1'b1;
          acc_rpos  = in_position_i;
        end
      end
      REQ_READ: begin
        if (pos_ge_cnt) begin
          acc_status = STAT_BADPOS;
        end else begin
          acc_job = JOB_READ;
          acc_re  = 1'b1;
        end
      end
      REQ_WRITE: begin
        if (pos_ge_cnt) begin
          acc_status = STAT_BADPOS;
        end else begin
          acc_we    = 1'b1;
          acc_waddr = pos_ext[AW-1:0];
        end
      end
      default: begin
        acc_job = JOB_DONE;
      end
    endcase
  end

  // Shift cursor: insert walks down from the old count, erase walks up to it.
  assign cursor_dec   = cursor_q - 1'b1;
  assign cursor_inc   = cursor_q + 1'b1;
  assign shift_active = (job_q == JOB_INSERT) ? (cursor_q > pos_q) : (cursor_q < end_q);

  always_comb begin
    count_d   = count_q;
    cursor_d  = cursor_q;
    end_d     = end_q;
    pos_d     = pos_q;
    val_d     = val_q;
    job_d     = job_q;
    status_d  = status_q;
    rpos_d    = rpos_q;
    wr_pend_d = 1'b0;
    wr_addr_d = wr_addr_q;
    if (cmd_i.capture) begin
      count_d  = acc_count;
      end_d    = count_q;
      pos_d    = pos_cw;
      val_d    = in_value_i;
      job_d    = acc_job;
      status_d = acc_status;
      rpos_d   = acc_rpos;
      cursor_d = (acc_job == JOB_INSERT) ? count_q : (pos_cw + 1'b1);
    end
    if (cmd_i.shift && shift_active) begin
      wr_pend_d = 1'b1;
      if (job_q == JOB_INSERT) begin
        wr_addr_d = cursor_q[AW-1:0];
        cursor_d  = cursor_dec;
      end else begin
        wr_addr_d = cursor_dec[AW-1:0];
        cursor_d  = cursor_inc;
      end
    end
  end

  // Store port selection: one read and one move write may share a shift cycle.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wr_addr_q;
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = pos_ext[AW-1:0];
    if (cmd_i.capture) begin
      ram_we    = acc_we;
      ram_waddr = acc_waddr;
      ram_wdata = in_value_i;
      ram_re    = acc_re;
    end else if (cmd_i.shift) begin
      ram_we    = wr_pend_q;
      ram_re    = shift_active;
      ram_raddr = (job_q == JOB_INSERT) ? cursor_dec[AW-1:0] : cursor_q[AW-1:0];
    end else if (cmd_i.finish) begin
      ram_we    = 1'b1;
      ram_waddr = pos_q[AW-1:0];
      ram_wdata = val_q;
    end
  end

  sal_ram #(
    .WIDTH(DATA_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      wr_pend_q <= 1'b0;
      job_q     <= JOB_DONE;
    end else begin
      count_q   <= count_d;
      wr_pend_q <= wr_pend_d;
      job_q     <= job_d;
    end
  end

  // Request payload registers.
  always_ff @(posedge clk_i) begin
    cursor_q  <= cursor_d;
    end_q     <= end_d;
    pos_q     <= pos_d;
    val_q     <= val_d;
    status_q  <= status_d;
    rpos_q    <= rpos_d;
    wr_addr_q <= wr_addr_d;
  end

  // Result register; it frees up when the beat is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_data_q   <= (job_q == JOB_READ) ? ram_rdata : '0;
      out_count_q  <= cnt_ext[CNT_W-1:0];
      out_status_q <= status_q;
      out_rpos_q   <= rpos_q;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign out_read_data_o       = out_data_q;
  assign out_element_count_o   = out_count_q;
  assign out_status_o          = out_status_q;
  assign out_result_position_o = out_rpos_q;

  assign stat_o.acc_job    = acc_job;
  assign stat_o.cur_job    = job_q;
  assign stat_o.shift_more = shift_active;
  assign stat_o.out_free   = !out_valid_q || out_ready_i;

  `ASSERT_NEVER(a_count_in_range, clk_i, rst_ni, count_q > CW'(DEPTH),
                "element count exceeds capacity")
  `ASSERT_PROP(a_move_only_in_shift, clk_i, rst_ni, wr_pend_q |-> cmd_i.shift,
               "pending element move outside the shift phase")
  `ASSERT_PROP(a_load_only_when_free, clk_i, rst_ni,
               cmd_i.load_out |-> (!out_valid_q || out_ready_i),
               "result loaded over an untaken beat")

endmodule

>>> design/shift_array_list_unit.sv
// Shift array list: a bounded ordered list of signed 32-bit words held in one RAM.
// Depends on sal_pkg, sal_ctrl and sal_dp.
//
// Usage: one request beat enters on the s_axis channel (tuser = request type,
// tdata = position and value) and exactly one result beat leaves on m_axis
// (read data, element count, status, result position). Requests are append,
// remove last, insert, erase, read and write by index.
// Steps: append, remove, write, refused and unused requests go from accept to the
// response state, as does read, whose data is registered from the store. Insert
// goes through shift, final write and response; erase through shift and response.
// Elements are moved one per cycle through the single write port of the store.
// One request is in work at a time; s_axis_tready is high only while no
// request is in work, and a new request may be taken while a finished result
// still waits in the output register. Insert and erase hold off the next
// request until their elements have moved and their result is loaded.
// Reset clears the element count and all control state; the store itself
// is not cleared, since only entries below the count are ever read.
// If m_axis_tready stays low, the result beat holds and the next request
// completes up to its response, then waits.
module shift_array_list_unit #(
  parameter int unsigned DEPTH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata from bit 0 up: position[8:0], value[40:9], zero fill[47:41].
  input  logic [47:0] s_axis_tdata,
  // tuser from bit 0 up: req_type[2:0].
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata from bit 0 up: read_data[31:0], element_count[40:32], status[42:41],
  // result_position[51:43], zero fill[55:52].
  output logic [55:0] m_axis_tdata
);

  import sal_pkg::*;

  cmd_t                     cmd;
  stat_t                    stat;
  logic signed [DATA_W-1:0] res_data;
  logic [CNT_W-1:0]         res_count;
  logic [STAT_W-1:0]        res_status;
  logic [POS_W-1:0]         res_rpos;

  sal_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  sal_dp #(
    .DEPTH(DEPTH)
  ) u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .stat_o               (stat),
    .in_req_type_i        (s_axis_tuser),
    .in_position_i        (s_axis_tdata[8:0]),
    .in_value_i           (s_axis_tdata[40:9]),
    .out_valid_o          (m_axis_tvalid),
    .out_ready_i          (m_axis_tready),
    .out_read_data_o      (res_data),
    .out_element_count_o  (res_count),
    .out_status_o         (res_status),
    .out_result_position_o(res_rpos)
  );

  // Pack the result beat.
  assign m_axis_tdata = {4'b0000, res_rpos, res_status, res_count, res_data};

endmodule

>>> tb/tb.sv
// Self-checking testbench for shift_array_list_unit: drives list requests on the slave stream
// and checks every result beat against an in-bench model of the bounded list.
// Depends on sal_pkg and the shift_array_list_unit RTL.
module tb;
  import sal_pkg::*;

  localparam int LIST_DEPTH    = 256;
  localparam int RANDOM_ITEMS  = 850;
  localparam int SETTLE_CYCLES = LIST_DEPTH + 8;
  localparam int REPORT_LIMIT  = 10;

  // Request kinds that the block treats as no operation.
  localparam logic [2:0] REQ_SPARE_A = 3'd6;
  localparam logic [2:0] REQ_SPARE_B = 3'd7;

  typedef struct {
    logic [2:0]  kind;
    logic [8:0]  pos;
    logic [31:0] val;
    logic        drain_first;
  } list_request_t;

  typedef struct {
    logic [31:0] rdata;
    logic [8:0]  count;
    status_e     status;
    logic [8:0]  rpos;
  } list_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata  = '0;
  logic [2:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;

  list_request_t pending_requests[$];
  list_result_t  expected_results[$];

  // Model of the list as seen by the block, advanced on every accepted beat.
  logic [31:0] list_words [LIST_DEPTH];
  int          list_len;

  // Running list length at generation time, used to aim positions.
  int gen_len;
  int items_accepted;
  int error_count;

  shift_array_list_unit #(
    .DEPTH(LIST_DEPTH)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // Clock and a single reset at the start of the run.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Idle rates: sender light and receiver heavy, then swapped, then no idling.
  function automatic int sender_idle_pct(input int n);
    if (n < 290) return 32;
    else if (n < 580) return 70;
    else return 0;
  endfunction

  function automatic int receiver_idle_pct(input int n);
    if (n < 290) return 70;
    else if (n < 580) return 32;
    else return 0;
  endfunction

  // Applies one request to the list model and returns the result it should give.
  function automatic list_result_t apply_list_request(input logic [2:0] kind,
                                                      input logic [8:0] pos,
                                                      input logic [31:0] val);
    list_result_t r;
    int p;
    r.rdata  = '0;
    r.status = STAT_OK;
    r.rpos   = '0;
    p        = int'(pos);
    case (kind)
      REQ_APPEND: begin
        if (list_len >= LIST_DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          list_words[list_len] = val;
          list_len++;
        end
      end
      REQ_POP: begin
        if (list_len == 0) r.status = STAT_EMPTY;
        else list_len--;
      end
      REQ_INSERT: begin
        if (p > list_len) begin
          r.status = STAT_BADPOS;
        end else if (list_len >= LIST_DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          for (int k = list_len; k > p; k--) list_words[k] = list_words[k-1];
          list_words[p] = val;
          list_len++;
          r.rpos = 9'(p + 1);
        end
      end
      REQ_ERASE: begin
        if (p >= list_len) begin
          r.status = STAT_BADPOS;
        end else begin
          for (int k = p + 1; k < list_len; k++) list_words[k-1] = list_words[k];
          list_len--;
          r.rpos = pos;
        end
      end
      REQ_READ: begin
        if (p >= list_len) r.status = STAT_BADPOS;
        else r.rdata = list_words[p];
      end
      REQ_WRITE: begin
        if (p >= list_len) r.status = STAT_BADPOS;
        else list_words[p] = val;
      end
      default: ;
    endcase
    r.count = 9'(list_len);
    return r;
  endfunction

  task automatic queue_request(input logic [2:0] kind, input logic [8:0] pos,
                               input logic [31:0] val);
    list_request_t r;
    r.kind        = kind;
    r.pos         = pos;
    r.val         = val;
    r.drain_first = 1'b0;
    pending_requests.insert(pending_requests.size(), r);
    // Track the length only to steer later positions toward the live range.
    case (kind)
      REQ_APPEND: if (gen_len < LIST_DEPTH) gen_len++;
      REQ_POP:    if (gen_len > 0) gen_len--;
      REQ_INSERT: if (int'(pos) <= gen_len && gen_len < LIST_DEPTH) gen_len++;
      REQ_ERASE:  if (int'(pos) < gen_len) gen_len--;
      default: ;
    endcase
  endtask

  // A marker that holds the sender until every expected result has come back.
  task automatic queue_pause();
    list_request_t r;
    r.kind        = '0;
    r.pos         = '0;
    r.val         = '0;
    r.drain_first = 1'b1;
    pending_requests.insert(pending_requests.size(), r);
  endtask

  // One random request, biased to grow or shrink the list toward the target length.
  task automatic queue_random_request(input int target);
    int roll;
    int grow_w;
    int shrink_w;
    int span;
    logic [2:0]  kind;
    logic [8:0]  pos;
    logic [31:0] val;
    if (gen_len < target) begin
      grow_w = 85; shrink_w = 0;
    end else if (gen_len > target) begin
      grow_w = 0; shrink_w = 85;
    end else begin
      grow_w = 35; shrink_w = 30;
    end
    roll = $urandom_range(99);
    if (roll < grow_w) begin
      kind = $urandom_range(1) ? REQ_APPEND : REQ_INSERT;
    end else if (roll < grow_w + shrink_w) begin
      kind = $urandom_range(1) ? REQ_POP : REQ_ERASE;
    end else begin
      roll = $urandom_range(9);
      if (roll < 4) kind = REQ_READ;
      else if (roll < 7) kind = REQ_WRITE;
      else if (roll == 7) kind = REQ_SPARE_A;
      else if (roll == 8) kind = REQ_SPARE_B;
      else kind = $urandom_range(1) ? REQ_APPEND : REQ_POP;
    end

    // Mostly a valid index, sometimes the boundary, sometimes anything.
    span = (kind == REQ_INSERT) ? gen_len : gen_len - 1;
    roll = $urandom_range(99);
    if (roll < 8 || span < 0) pos = 9'($urandom);
    else if (roll < 14) pos = 9'(gen_len);
    else if (roll < 18) pos = '0;
    else pos = 9'($urandom_range(span));

    roll = $urandom_range(99);
    if (roll < 3) val = 32'h0000_0000;
    else if (roll < 6) val = 32'h7fff_ffff;
    else if (roll < 9) val = 32'h8000_0000;
    else if (roll < 12) val = 32'hffff_ffff;
    else val = $urandom;

    queue_request(kind, pos, val);
  endtask

  // Stimulus, then the end-of-run check.
  initial begin
    int target;
    gen_len = 0;

    // Empty-list refusals.
    queue_request(REQ_POP,    9'd0, 32'h0);
    queue_request(REQ_ERASE,  9'd0, 32'h0);
    queue_request(REQ_READ,   9'd0, 32'h0);
    queue_request(REQ_WRITE,  9'd0, 32'h1234_5678);
    queue_request(REQ_INSERT, 9'd1, 32'h0);
    // Build a short list with the value extremes, inserting at front, end and middle.
    queue_request(REQ_INSERT, 9'd0,   32'h7fff_ffff);
    queue_request(REQ_APPEND, 9'd0,   32'h8000_0000);
    queue_request(REQ_APPEND, 9'h1ff, 32'hffff_ffff);
    queue_request(REQ_INSERT, 9'd3,   32'h0000_0000);
    queue_request(REQ_INSERT, 9'd1,   32'h5555_5555);
    // Reads at both ends, at index 1 and one past the end, then a write and its read-back.
    queue_request(REQ_READ, 9'd0, 32'h0);
    queue_request(REQ_READ, 9'd1, 32'h0);
    queue_request(REQ_READ, 9'd4, 32'h0);
    queue_request(REQ_READ, 9'd5, 32'h0);
    queue_request(REQ_WRITE, 9'd2, 32'haaaa_aaaa);
    queue_request(REQ_READ,  9'd2, 32'h0);
    // Erase at the front, at the last index and far out of range; insert far past the end.
    queue_request(REQ_ERASE,  9'd0,   32'h0);
    queue_request(REQ_ERASE,  9'd3,   32'h0);
    queue_request(REQ_ERASE,  9'h1ff, 32'h0);
    queue_request(REQ_INSERT, 9'h100, 32'h0);
    // Unused request kinds, then a pop.
    queue_request(REQ_SPARE_A, 9'h1ff, 32'hffff_ffff);
    queue_request(REQ_SPARE_B, 9'd0,   32'h0);
    queue_request(REQ_POP,     9'd0,   32'h0);
    queue_pause();

    // Random part: short lists first, then fill to capacity, then drain to empty.
    target = 4;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 280 || i == 560) queue_pause();
      if (i < 200) begin
        if (i % 20 == 0) target = $urandom_range(16);
      end else if (i < 560) begin
        target = LIST_DEPTH;
      end else begin
        target = 0;
      end
      queue_random_request(target);
    end

    while (pending_requests.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Request driver: holds a beat until it is taken, predicts its result on accept.
  always @(posedge clk_i) begin
    logic          accepted;
    list_request_t nxt;
    if (!rst_ni) begin
      s_axis_tvalid  <= 1'b0;
      list_len       = 0;
      items_accepted <= 0;
    end else begin
      accepted = s_axis_tvalid && s_axis_tready;
      if (accepted) begin
        expected_results.insert(expected_results.size(),
                                apply_list_request(s_axis_tuser, s_axis_tdata[8:0],
                                                   s_axis_tdata[40:9]));
        items_accepted <= items_accepted + 1;
      end
      if (!s_axis_tvalid || accepted) begin
        if (pending_requests.size() != 0 && pending_requests[0].drain_first &&
            expected_results.size() == 0)
          void'(pending_requests.pop_front());
        if (pending_requests.size() != 0 && !pending_requests[0].drain_first &&
            $urandom_range(99) >= sender_idle_pct(items_accepted)) begin
          nxt = pending_requests.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= nxt.kind;
          s_axis_tdata  <= {7'b0, nxt.val, nxt.pos};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compares each result beat with the oldest expectation.
  always @(posedge clk_i) begin
    list_result_t got;
    list_result_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.rdata  = m_axis_tdata[31:0];
        got.count  = m_axis_tdata[40:32];
        got.status = status_e'(m_axis_tdata[42:41]);
        got.rpos   = m_axis_tdata[51:43];
        if (expected_results.size() == 0) begin
          error_count++;
          if (error_count <= REPORT_LIMIT)
            $display("unexpected result beat: data %h count %0d status %0d pos %0d",
                     got.rdata, got.count, got.status, got.rpos);
        end else begin
          want = expected_results.pop_front();
          if (got.rdata !== want.rdata || got.count !== want.count ||
              got.status !== want.status || got.rpos !== want.rpos) begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
              $display("mismatch: expected data %h count %0d status %0d pos %0d, %s",
                       want.rdata, want.count, want.status, want.rpos,
                       $sformatf("got data %h count %0d status %0d pos %0d",
                                 got.rdata, got.count, got.status, got.rpos));
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= receiver_idle_pct(items_accepted));
    end
  end

  // Hard limit on run time.
  initial begin
    #15_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+design
design/sal_pkg.sv
design/sal_ram.sv
design/sal_ctrl.sv
design/sal_dp.sv
design/shift_array_list_unit.sv
tb/tb.sv
